// ===== src/yti_pkg.sv =====
// ----------------------------------------------------------------------------
// yti_pkg
// Shared constants, types and register codes of the YUVA to I420 chroma
// subsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package yti_pkg;

  // Frame bounds
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Line buffer: one pair sum per column pair
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Position counters and clamped dimensions
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WDIM_W = COL_W + 1;
  localparam int HDIM_W = ROW_W + 1;

  // Sample and sum widths
  localparam int PIX_W   = 8;
  localparam int SUM_W   = PIX_W + 1;
  localparam int LINE_W  = 2 * SUM_W;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Line buffer access issued at the input stage
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [LINE_AW-1:0] addr;
    logic [LINE_W-1:0]  wdata;
  } line_req_t;

  // Item handed from the input stage to the output stage
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic             from_line;
    logic [SUM_W-1:0] cb_sum;
    logic [SUM_W-1:0] cr_sum;
    logic             frame_end;
  } stage_item_t;

  // Result item
  typedef struct packed {
    logic [PIX_W-1:0] luma_out;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb_out;
    logic [PIX_W-1:0] cr_out;
    logic             frame_end;
  } result_t;

endpackage

`default_nettype wire

// ===== src/yti_if.sv =====
// ----------------------------------------------------------------------------
// yti_if
// Valid/ready channels of the subsampler: pixel input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface yti_in_if;
  logic                    valid;
  logic                    ready;
  logic [yti_pkg::PIX_W-1:0] luma_in;
  logic [yti_pkg::PIX_W-1:0] cb_in;
  logic [yti_pkg::PIX_W-1:0] cr_in;

  modport source (output valid, output luma_in, output cb_in, output cr_in, input ready);
  modport sink   (input valid, input luma_in, input cb_in, input cr_in, output ready);
endinterface

interface yti_out_if;
  logic                    valid;
  logic                    ready;
  logic [yti_pkg::PIX_W-1:0] luma_out;
  logic                    chroma_valid;
  logic [yti_pkg::PIX_W-1:0] cb_out;
  logic [yti_pkg::PIX_W-1:0] cr_out;
  logic                    frame_end;

  modport source (output valid, output luma_out, output chroma_valid, output cb_out,
                  output cr_out, output frame_end, input ready);
  modport sink   (input valid, input luma_out, input chroma_valid, input cb_out,
                  input cr_out, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/yti_ram.sv =====
// ----------------------------------------------------------------------------
// yti_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                        wdata,
  output      logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/yti_scan.sv =====
// ----------------------------------------------------------------------------
// yti_scan
// Input stage: frame registers, raster position, horizontal pair sums and
// line buffer requests.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [yti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [yti_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          accept,
  input  wire logic [yti_pkg::PIX_W-1:0]     luma_in,
  input  wire logic [yti_pkg::PIX_W-1:0]     cb_in,
  input  wire logic [yti_pkg::PIX_W-1:0]     cr_in,
  output      yti_pkg::line_req_t            line_req,
  output      yti_pkg::stage_item_t          item
);

  logic [yti_pkg::CFG_W-1:0]  width_r, width_nxt;
  logic [yti_pkg::CFG_W-1:0]  height_r, height_nxt;
  logic [yti_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [yti_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [yti_pkg::PIX_W-1:0]  cb_hold_r, cb_hold_nxt;
  logic [yti_pkg::PIX_W-1:0]  cr_hold_r, cr_hold_nxt;

  logic [yti_pkg::WDIM_W-1:0] last_col_idx;
  logic [yti_pkg::HDIM_W-1:0] last_row_idx;
  logic                       last_col, last_row, odd_col, odd_row, pair_done;
  logic [yti_pkg::SUM_W-1:0]  cb_sum, cr_sum;

  // Clamp the dimensions and form the index of the last column and row
  always_comb begin
    if (width_r == '0) begin
      last_col_idx = '0;
    end else if (width_r > yti_pkg::MAX_WIDTH) begin
      last_col_idx = yti_pkg::WDIM_W'(yti_pkg::MAX_WIDTH - 1);
    end else begin
      last_col_idx = yti_pkg::WDIM_W'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      last_row_idx = '0;
    end else if (height_r > yti_pkg::MAX_HEIGHT) begin
      last_row_idx = yti_pkg::HDIM_W'(yti_pkg::MAX_HEIGHT - 1);
    end else begin
      last_row_idx = yti_pkg::HDIM_W'(height_r - 1'b1);
    end
  end

  assign last_col = yti_pkg::WDIM_W'(col_r) >= last_col_idx;
  assign last_row = yti_pkg::HDIM_W'(row_r) >= last_row_idx;
  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];

  // Horizontal pair sums; double a lone last column
  always_comb begin
    cb_sum    = '0;
    cr_sum    = '0;
    pair_done = 1'b0;
    if (odd_col) begin
      cb_sum    = yti_pkg::SUM_W'(cb_hold_r) + yti_pkg::SUM_W'(cb_in);
      cr_sum    = yti_pkg::SUM_W'(cr_hold_r) + yti_pkg::SUM_W'(cr_in);
      pair_done = 1'b1;
    end else if (last_col) begin
      cb_sum    = {cb_in, 1'b0};
      cr_sum    = {cr_in, 1'b0};
      pair_done = 1'b1;
    end
  end

  // Line buffer: store on the first row of a pair, fetch on the second
  always_comb begin
    line_req.addr  = yti_pkg::LINE_AW'(col_r >> 1);
    line_req.wdata = {cb_sum, cr_sum};
    line_req.rd_en = accept && pair_done && odd_row;
    line_req.wr_en = accept && pair_done && !odd_row && !last_row;
  end

  always_comb begin
    item.luma         = luma_in;
    item.chroma_valid = pair_done && (odd_row || last_row);
    item.from_line    = odd_row;
    item.cb_sum       = cb_sum;
    item.cr_sum       = cr_sum;
    item.frame_end    = last_col && last_row;
  end

  // Next state
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    cb_hold_nxt = cb_hold_r;
    cr_hold_nxt = cr_hold_r;
    if (cfg_wr_en) begin
      case (yti_pkg::cfg_reg_t'(cfg_index))
        yti_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        yti_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
    if (accept) begin
      if (!odd_col) begin
        cb_hold_nxt = cb_in;
        cr_hold_nxt = cr_in;
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= yti_pkg::CFG_W'(1);
      height_r  <= yti_pkg::CFG_W'(1);
      col_r     <= '0;
      row_r     <= '0;
      cb_hold_r <= '0;
      cr_hold_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      cb_hold_r <= cb_hold_nxt;
      cr_hold_r <= cr_hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/yti_emit.sv =====
// ----------------------------------------------------------------------------
// yti_emit
// Output stage: joins the line buffer read with the pair sums, averages the
// block and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_emit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       out_ready,
  input  wire yti_pkg::stage_item_t       item,
  input  wire logic [yti_pkg::LINE_W-1:0] line_rdata,
  output      logic                       accept,
  output      logic                       in_ready,
  output      logic                       out_valid,
  output      yti_pkg::result_t           result
);

  logic                  s1_valid_r, s1_valid_nxt;
  yti_pkg::stage_item_t  s1_item_r, s1_item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  yti_pkg::result_t      result_r, result_nxt;
  logic                  advance;
  logic [yti_pkg::SUM_W:0] cb_total, cr_total;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  // Vertical sum: line entry plus this row, or this row counted twice
  always_comb begin
    if (s1_item_r.from_line) begin
      cb_total = {1'b0, line_rdata[yti_pkg::LINE_W-1:yti_pkg::SUM_W]} + {1'b0, s1_item_r.cb_sum};
      cr_total = {1'b0, line_rdata[yti_pkg::SUM_W-1:0]} + {1'b0, s1_item_r.cr_sum};
    end else begin
      cb_total = {s1_item_r.cb_sum, 1'b0};
      cr_total = {s1_item_r.cr_sum, 1'b0};
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_item_nxt   = s1_item_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      s1_valid_nxt = 1'b0;
      if (s1_valid_r) begin
        out_valid_nxt           = 1'b1;
        result_nxt.luma_out     = s1_item_r.luma;
        result_nxt.chroma_valid = s1_item_r.chroma_valid;
        result_nxt.cb_out       = s1_item_r.chroma_valid ? cb_total[yti_pkg::SUM_W:2] : '0;
        result_nxt.cr_out       = s1_item_r.chroma_valid ? cr_total[yti_pkg::SUM_W:2] : '0;
        result_nxt.frame_end    = s1_item_r.frame_end;
      end
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    result_r  <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// ===== src/yuva_to_i420_subsample.sv =====
// ----------------------------------------------------------------------------
// yuva_to_i420_subsample
// YUV 4:4:4 raster pixels in, luma pass-through with 2x2 averaged chroma out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries                                     Protocol
//   in_bus   sink       luma_in, cb_in, cr_in                       valid/ready
//   out_bus  source     luma_out, chroma_valid, cb_out, cr_out,     valid/ready
//                       frame_end
//   cfg_*    sink       register index and data                     write enable
//
// One item a cycle while out_bus is not stalled; an accepted item passes
// through the stage register (with the line buffer read), then the output
// register, before it shows on out_bus.
// The line buffer is a single-port RAM with at most one access per item, so
// it never limits the rate.
// Reset (rst_n low, synchronous) empties the pipeline, sets both dimensions
// to 1 and restarts the raster position at the top-left pixel.
// A stall on out_bus holds the output register; one further item is taken
// into the stage behind it before in_bus.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module yuva_to_i420_subsample (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  yti_in_if.sink                             in_bus,
  yti_out_if.source                          out_bus,
  input  wire logic                          cfg_wr_en,
  input  wire logic [yti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [yti_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                       accept;
  logic                       in_ready;
  logic                       out_valid;
  yti_pkg::line_req_t         line_req;
  yti_pkg::stage_item_t       item;
  yti_pkg::result_t           result;
  logic [yti_pkg::LINE_W-1:0] line_rdata;

  // Raster position, pair sums and line buffer requests
  yti_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .luma_in   (in_bus.luma_in),
    .cb_in     (in_bus.cb_in),
    .cr_in     (in_bus.cr_in),
    .line_req  (line_req),
    .item      (item)
  );

  // Pair sums of the first row of each row pair: {cb, cr}
  yti_ram #(
    .WIDTH (yti_pkg::LINE_W),
    .DEPTH (yti_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .wr_en (line_req.wr_en),
    .rd_en (line_req.rd_en),
    .addr  (line_req.addr),
    .wdata (line_req.wdata),
    .rdata (line_rdata)
  );

  // Averaging and output register; read data is held until the item moves on
  yti_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .out_ready  (out_bus.ready),
    .item       (item),
    .line_rdata (line_rdata),
    .accept     (accept),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid;
  assign out_bus.luma_out     = result.luma_out;
  assign out_bus.chroma_valid = result.chroma_valid;
  assign out_bus.cb_out       = result.cb_out;
  assign out_bus.cr_out       = result.cr_out;
  assign out_bus.frame_end    = result.frame_end;

endmodule

`default_nettype wire

// ===== src/yti_checker.sv =====
// ----------------------------------------------------------------------------
// yti_checker
// Port-level checks of the subsampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      chroma_valid,
  input wire logic [yti_pkg::PIX_W-1:0] cb_out,
  input wire logic [yti_pkg::PIX_W-1:0] cr_out
);

  logic [1:0] inflight_r, inflight_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // No result without an item accepted before it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result without an accepted item");

  // At most two items held inside
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r != 2'd3)
    else $error("more than two items in flight");

  // Chroma fields read zero on pixels that close no block
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !chroma_valid) |-> (cb_out == '0 && cr_out == '0))
    else $error("chroma set without chroma_valid");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn under stall");

endmodule

bind yuva_to_i420_subsample yti_checker u_yti_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .chroma_valid (out_bus.chroma_valid),
  .cb_out       (out_bus.cb_out),
  .cr_out       (out_bus.cr_out)
);

`default_nettype wire

// ===== tb/sv/tb_yuva_to_i420_subsample.sv =====
// ----------------------------------------------------------------------------
// tb_yuva_to_i420_subsample
// Self-checking bench for the YUVA to I420 chroma subsampler. Frames of
// pixels are streamed through the valid/ready input while the output is
// stalled at random. Each accepted item is run through a cycle-free model of
// the 2x2 chroma averaging, and every result item is compared field by field
// with the oldest prediction. Directed frames and a back-pressure burst come
// first, then random shapes, mid-frame shrinks and out-of-range registers.
// ----------------------------------------------------------------------------

module tb_yuva_to_i420_subsample;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int IDLE_PCT      = 31;     // chance in a hundred that a side idles
  localparam int HOLD_CYCLES   = 80;     // long output stall for back-pressure
  localparam int DRAIN_CYCLES  = 4;      // two-stage pipeline plus margin
  localparam int RANDOM_TARGET = 260;

  typedef struct packed {
    logic [yti_pkg::PIX_W-1:0] y;
    logic [yti_pkg::PIX_W-1:0] u;
    logic [yti_pkg::PIX_W-1:0] v;
  } pixel_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [yti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [yti_pkg::CFG_W-1:0]     cfg_wdata = '0;

  logic                          px_valid  = 1'b0;
  logic [yti_pkg::PIX_W-1:0]     px_luma   = '0;
  logic [yti_pkg::PIX_W-1:0]     px_cb     = '0;
  logic [yti_pkg::PIX_W-1:0]     px_cr     = '0;
  logic                          res_ready = 1'b0;

  yti_in_if  in_bus();
  yti_out_if out_bus();

  assign in_bus.valid   = px_valid;
  assign in_bus.luma_in = px_luma;
  assign in_bus.cb_in   = px_cb;
  assign in_bus.cr_in   = px_cr;
  assign out_bus.ready  = res_ready;

  yuva_to_i420_subsample DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Subsampler model state: its own copy of the registers and the raster
  // position, the held even-column chroma and the line of pair sums.
  // --------------------------------------------------------------------------
  logic [yti_pkg::CFG_W-1:0] width_reg  = 13'd1;
  logic [yti_pkg::CFG_W-1:0] height_reg = 13'd1;
  int                        pos_col    = 0;
  int                        pos_row    = 0;
  logic [yti_pkg::PIX_W-1:0] cb_hold    = '0;
  logic [yti_pkg::PIX_W-1:0] cr_hold    = '0;
  // Left unset on purpose: a read of an unwritten entry shows up as X.
  logic [yti_pkg::SUM_W-1:0] cb_line [yti_pkg::LINE_DEPTH];
  logic [yti_pkg::SUM_W-1:0] cr_line [yti_pkg::LINE_DEPTH];

  pixel_t           pixel_q[$];          // pixels waiting to be offered
  yti_pkg::result_t expected_px_q[$];    // predicted result items, oldest first
  pixel_t           next_px;
  yti_pkg::result_t seen_px;
  int               queued_px      = 0;
  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               hold_req       = 0;
  int               hold_served    = 0;
  int               hold_left      = 0;
  bit               steady         = 1'b0;  // both sides stop idling while set

  // A zero dimension acts as one; anything past the bound saturates.
  function automatic int clamp_dim(logic [yti_pkg::CFG_W-1:0] v, int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Advance the model by one pixel and return the result item it causes.
  function automatic yti_pkg::result_t subsample_pixel(logic [yti_pkg::PIX_W-1:0] y,
                                                       logic [yti_pkg::PIX_W-1:0] u,
                                                       logic [yti_pkg::PIX_W-1:0] v);
    int               w;
    int               h;
    int               idx;
    int               cb_sum;
    int               cr_sum;
    bit               last_col;
    bit               last_row;
    bit               pair_done;
    yti_pkg::result_t r;
    w         = clamp_dim(width_reg, yti_pkg::MAX_WIDTH);
    h         = clamp_dim(height_reg, yti_pkg::MAX_HEIGHT);
    last_col  = pos_col >= w - 1;
    last_row  = pos_row >= h - 1;
    idx       = (pos_col >> 1) % yti_pkg::LINE_DEPTH;
    pair_done = 1'b0;
    cb_sum    = 0;
    cr_sum    = 0;
    r         = '0;
    r.luma_out = y;

    if ((pos_col % 2) != 0) begin
      cb_sum    = int'(cb_hold) + int'(u);
      cr_sum    = int'(cr_hold) + int'(v);
      pair_done = 1'b1;
    end else begin
      cb_hold = u;
      cr_hold = v;
      // Odd width: double the lone last column.
      if (last_col) begin
        cb_sum    = 2 * int'(u);
        cr_sum    = 2 * int'(v);
        pair_done = 1'b1;
      end
    end

    if (pair_done) begin
      if ((pos_row % 2) != 0) begin
        r.chroma_valid = 1'b1;
        r.cb_out       = yti_pkg::PIX_W'((int'(cb_line[idx]) + cb_sum) >> 2);
        r.cr_out       = yti_pkg::PIX_W'((int'(cr_line[idx]) + cr_sum) >> 2);
      end else if (last_row) begin
        // Odd height: count the last row twice.
        r.chroma_valid = 1'b1;
        r.cb_out       = yti_pkg::PIX_W'((2 * cb_sum) >> 2);
        r.cr_out       = yti_pkg::PIX_W'((2 * cr_sum) >> 2);
      end else begin
        cb_line[idx] = yti_pkg::SUM_W'(cb_sum);
        cr_line[idx] = yti_pkg::SUM_W'(cr_sum);
      end
    end

    r.frame_end = last_col && last_row;

    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
    return r;
  endfunction

  // Count the pixels still needed to close the current frame.
  function automatic int pixels_to_frame_end();
    int w;
    int h;
    int c;
    int r;
    int n;
    bit done;
    w    = clamp_dim(width_reg, yti_pkg::MAX_WIDTH);
    h    = clamp_dim(height_reg, yti_pkg::MAX_HEIGHT);
    c    = pos_col;
    r    = pos_row;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      n++;
      if (c >= w - 1) begin
        if (r >= h - 1) done = 1'b1;
        else begin
          c = 0;
          r++;
        end
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  // Lean on the extremes now and then.
  function automatic logic [yti_pkg::PIX_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return yti_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic check_field(string name, logic [yti_pkg::PIX_W-1:0] exp_v,
                             logic [yti_pkg::PIX_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued pixels, idling at random. Predict each item at the
  // edge that accepts it, so the model sees exactly the accepted stream.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      px_valid <= 1'b0;
    end else begin
      if (px_valid && in_bus.ready)
        expected_px_q.push_back(subsample_pixel(px_luma, px_cb, px_cr));
      // Hold the offered item until it is taken; only then move on.
      if (!px_valid || in_bus.ready) begin
        if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_px  = pixel_q.pop_front();
          px_valid <= 1'b1;
          px_luma  <= next_px.y;
          px_cb    <= next_px.u;
          px_cr    <= next_px.v;
        end else begin
          px_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result item against the oldest prediction,
  // then choose the next ready. A hold request stalls the output for a long
  // stretch so that the block fills and drops its input ready.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (out_bus.valid && res_ready) begin
        if (expected_px_q.size() == 0) begin
          mismatch_count++;
          $error("result item with no prediction waiting");
        end else begin
          seen_px = expected_px_q.pop_front();
          check_field("luma_out", seen_px.luma_out, out_bus.luma_out);
          check_field("chroma_valid", seen_px.chroma_valid, out_bus.chroma_valid);
          check_field("cb_out", seen_px.cb_out, out_bus.cb_out);
          check_field("cr_out", seen_px.cr_out, out_bus.cr_out);
          check_field("frame_end", seen_px.frame_end, out_bus.frame_end);
        end
      end
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_pixel(logic [yti_pkg::PIX_W-1:0] y, logic [yti_pkg::PIX_W-1:0] u,
                            logic [yti_pkg::PIX_W-1:0] v);
    pixel_q.push_back('{y, u, v});
    queued_px++;
  endtask

  task automatic push_random(int n);
    repeat (n) push_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  // Wait until every queued pixel has been taken and every result has come.
  // Sample on the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || px_valid || expected_px_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; the model takes the value at the same edge as the block.
  task automatic write_reg(yti_pkg::cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= yti_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == yti_pkg::REG_FRAME_WIDTH) width_reg = yti_pkg::CFG_W'(value);
    else height_reg = yti_pkg::CFG_W'(value);
  endtask

  // Drain, then pad the frame in flight out to its last pixel.
  task automatic finish_frame();
    wait_idle();
    if (pos_col != 0 || pos_row != 0) begin
      push_random(pixels_to_frame_end());
      wait_idle();
    end
  endtask

  // Change shape only on a frame boundary, so no odd row can reach a line
  // entry that its own frame has not written.
  task automatic set_frame(int w, int h);
    finish_frame();
    write_reg(yti_pkg::REG_FRAME_WIDTH, w);
    write_reg(yti_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic run_frames(int w, int h, int frames);
    set_frame(w, h);
    push_random(clamp_dim(yti_pkg::CFG_W'(w), yti_pkg::MAX_WIDTH) *
                clamp_dim(yti_pkg::CFG_W'(h), yti_pkg::MAX_HEIGHT) * frames);
  endtask

  // Stop part way through a frame, then set a width no wider and a new height.
  // Only a width no wider is safe here: a wider one would send an odd row to
  // line entries that the row above never wrote.
  task automatic shrink_mid_frame();
    int w;
    int h;
    w = $urandom_range(12, 4);
    h = $urandom_range(8, 3);
    set_frame(w, h);
    push_random($urandom_range(w * h - 1, 1));
    wait_idle();
    write_reg(yti_pkg::REG_FRAME_WIDTH, $urandom_range(w, 0));
    write_reg(yti_pkg::REG_FRAME_HEIGHT, $urandom_range(8, 0));
    finish_frame();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int start_px;
    int w;
    int h;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // One 2x2 block: full-scale U, near-zero V, to show truncation.
    set_frame(2, 2);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd128, 8'd255, 8'd1);
    push_pixel(8'd1, 8'd255, 8'd1);

    // Odd width and odd height together: doubled last column and last row.
    set_frame(3, 3);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd17, 8'd1, 8'd2);
    push_pixel(8'd34, 8'd255, 8'd255);
    push_pixel(8'd51, 8'd0, 8'd0);
    push_pixel(8'd68, 8'd254, 8'd253);
    push_pixel(8'd85, 8'd3, 8'd4);
    push_pixel(8'd102, 8'd128, 8'd127);
    push_pixel(8'd255, 8'd9, 8'd250);

    // Zero dimensions act as one: every pixel is a whole frame.
    set_frame(0, 0);
    push_pixel(8'd77, 8'd255, 8'd0);
    push_pixel(8'd200, 8'd1, 8'd254);

    // Single column, two rows: doubled column feeds a real row pair.
    set_frame(1, 2);
    push_pixel(8'd255, 8'd200, 8'd100);
    push_pixel(8'd0, 8'd55, 8'd155);

    // Back-pressure: stall the output long while the input keeps offering.
    set_frame(6, 10);
    push_random(60);
    hold_req++;

    // A stretch with no idling on either side.
    set_frame(10, 6);
    steady = 1'b1;
    push_random(60);
    wait_idle();
    steady = 1'b0;

    // Random frame shapes, now and then cut short and narrowed mid-frame.
    start_px = queued_px;
    while (queued_px - start_px < RANDOM_TARGET) begin
      if ($urandom_range(4) == 0) begin
        shrink_mid_frame();
      end else if ($urandom_range(9) == 0) begin
        w = $urandom_range(40, 13);
        h = $urandom_range(3, 0);
        run_frames(w, h, 1);
      end else begin
        w = $urandom_range(12, 0);
        h = $urandom_range(8, 0);
        run_frames(w, h, $urandom_range(2, 1));
      end
    end

    // Register extremes: start a frame at all-ones dimensions, which
    // saturate, then narrow it part way along its first row.
    set_frame(8191, 8191);
    push_random(10);
    wait_idle();
    write_reg(yti_pkg::REG_FRAME_WIDTH, 4);
    write_reg(yti_pkg::REG_FRAME_HEIGHT, 2);
    finish_frame();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
